// ----- hw/rtl/gf2m_arith_unit_assert.svh -----
// Assertion macros for the GF(2^m) arithmetic unit.
// Expects signals named clock and reset in the including module.
`ifndef GF2M_ARITH_UNIT_ASSERT_SVH
`define GF2M_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define GF2M_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define GF2M_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/gf2m_pkg.sv -----
// Shared types and constants for the GF(2^m) arithmetic unit.
// No dependencies.
`default_nettype none

package gf2m_pkg;

   localparam int ELEM_W                  = 64;
   localparam int FIELD_W_W               = 7;
   localparam int CSR_DATA_W              = 64;
   localparam int CELL_STEPS              = 8;
   localparam int DEFAULT_MAX_FIELD_WIDTH = 64;

   localparam logic [FIELD_W_W-1:0] MIN_FIELD_WIDTH   = 7'd2;
   localparam logic [FIELD_W_W-1:0] FIELD_WIDTH_RESET = 7'd8;
   localparam logic [ELEM_W-1:0]    POLY_RESET        = 64'd29;
   localparam logic [ELEM_W-1:0]    ELEM_ONE          = 64'd1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2,
      OP_INV = 2'd3
   } op_type;

   typedef enum logic {
      CSR_FIELD_WIDTH    = 1'b0,
      CSR_REDUCTION_POLY = 1'b1
   } csr_index_type;

   // Field setup broadcast to every cell.
   typedef struct packed {
      logic [FIELD_W_W-1:0] width;
      logic [ELEM_W-1:0]    mask;
      logic [ELEM_W-1:0]    top;
      logic [ELEM_W-1:0]    poly;
   } field_cfg_type;

   // One slot of the cell chain: squaring multiplier (s*) and
   // accumulator multiplier (a*), each as shifted operand x, remaining
   // multiplier bits y and partial product p.
   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic                 div_by_zero;
      logic [ELEM_W-1:0]    sx;
      logic [ELEM_W-1:0]    sy;
      logic [ELEM_W-1:0]    sp;
      logic [ELEM_W-1:0]    ax;
      logic [ELEM_W-1:0]    ay;
      logic [ELEM_W-1:0]    ap;
   } stage_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gf2m_if.sv -----
// Item channels of the GF(2^m) arithmetic unit: request and response.
// Depends on gf2m_pkg.
`default_nettype none

interface gf2m_req_if;
   logic                          valid;
   logic                          ready;
   gf2m_pkg::op_type              op;
   logic [gf2m_pkg::ELEM_W-1:0]   operand_a;
   logic [gf2m_pkg::ELEM_W-1:0]   operand_b;

   modport source (output valid, output op, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b,
                   output ready);
endinterface

interface gf2m_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gf2m_pkg::ELEM_W-1:0]   result;
   logic                          div_by_zero;

   modport source (output valid, output result, output div_by_zero, input ready);
   modport sink   (input valid, input result, input div_by_zero, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gf2m_arith_unit.sv -----
// GF(2^m) arithmetic unit top level: config registers and cell chain.
// Depends on gf2m_pkg, gf2m_if, gf2m_csr, gf2m_cell and the assert macros.
`default_nettype none

`include "gf2m_arith_unit_assert.svh"

// Add, multiply, divide and inverse in GF(2^w), w = 2..MAX_FIELD_WIDTH,
// with the low w bits of the reduction polynomial held in a register (the
// x^w term is implicit). The datapath is a chain of MAX_FIELD_WIDTH rounds;
// each round carries an element s and an accumulator acc and, per item,
// squares s and optionally multiplies acc by s, both bit-serially over
// ceil(MAX_FIELD_WIDTH/8) cells of 8 shift-and-add steps each. Inverse
// starts with s=a, acc=1; divide with s=b, acc=a; multiply with s=b,
// acc=a and only round 0 active; add passes a^b. One item is accepted
// per cycle unless the chain is held; each item passes through the
// registers of all cells of the chain in order. The whole chain holds
// when a finished item waits at the response side and the response is
// not taken. Divide with nonzero a and zero b returns 0 with div_by_zero
// set. Configuration writes are for idle periods only.
module gf2m_arith_unit #(
   parameter int MAX_FIELD_WIDTH = gf2m_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   gf2m_req_if.sink                               req_ch,
   gf2m_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_write_en,
   input  gf2m_pkg::csr_index_type                csr_index,
   input  wire logic [gf2m_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gf2m_pkg::*;

   // cells per multiplication, and total chain length
   localparam int CellsPerMul = (MAX_FIELD_WIDTH + CELL_STEPS - 1) / CELL_STEPS;
   localparam int NumCells    = MAX_FIELD_WIDTH * CellsPerMul;

   field_cfg_type     cfg;
   stage_type         chain [NumCells+1];
   stage_type         entry;
   logic              advance;
   logic [ELEM_W-1:0] opnd_a;
   logic [ELEM_W-1:0] opnd_b;

   gf2m_csr #(
      .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // global hold: move only if the output slot is empty or being taken
   assign advance      = !chain[NumCells].valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign opnd_a = req_ch.operand_a & cfg.mask;
   assign opnd_b = req_ch.operand_b & cfg.mask;

   // load the round-0 state for each operation
   always_comb begin
      entry             = '0;
      entry.valid       = req_ch.valid;
      entry.op          = req_ch.op;
      entry.div_by_zero = (req_ch.op == OP_DIV) && (opnd_a != '0) && (opnd_b == '0);
      entry.sx          = (req_ch.op == OP_INV) ? opnd_a : opnd_b;
      case (req_ch.op)
         OP_ADD:  entry.ax = opnd_a ^ opnd_b;
         OP_INV:  entry.ax = ELEM_ONE;
         default: entry.ax = opnd_a;
      endcase
   end

   assign chain[0] = entry;

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      localparam int Round = k / CellsPerMul;
      localparam int Pos   = k % CellsPerMul;

      gf2m_cell #(
         .ROUND (Round),
         .FIRST (Pos == 0),
         .LAST  (Pos == CellsPerMul - 1)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cfg     (cfg),
         .stage_i (chain[k]),
         .stage_o (chain[k+1])
      );
   end

   // last cell register doubles as the output register
   assign rsp_ch.valid       = chain[NumCells].valid;
   assign rsp_ch.result      = chain[NumCells].ax;
   assign rsp_ch.div_by_zero = chain[NumCells].div_by_zero;

   `GF2M_ASSERT_IMPL(a_dbz_zero_result, rsp_ch.valid && rsp_ch.div_by_zero, rsp_ch.result == '0, "divide-by-zero item with nonzero result")
   `GF2M_ASSERT_IMPL(a_ready_when_empty, !rsp_ch.valid, req_ch.ready, "input stalled with empty output slot")
   `GF2M_ASSERT_NEXT(a_reset_clears_out, reset, !rsp_ch.valid, "response valid right after reset")

endmodule

`default_nettype wire

// ----- hw/rtl/gf2m_csr.sv -----
// Field width and reduction polynomial registers, plus derived masks.
// Depends on gf2m_pkg.
`default_nettype none

module gf2m_csr #(
   parameter int MAX_FIELD_WIDTH = gf2m_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  gf2m_pkg::csr_index_type                  csr_index,
   input  wire logic [gf2m_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output gf2m_pkg::field_cfg_type                  cfg
);
   import gf2m_pkg::*;

   localparam logic [FIELD_W_W-1:0] MaxWidth = FIELD_W_W'(MAX_FIELD_WIDTH);

   logic [FIELD_W_W-1:0] field_width_ff;
   logic [ELEM_W-1:0]    poly_ff;
   logic [FIELD_W_W-1:0] eff_width;
   logic [FIELD_W_W-1:0] top_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= FIELD_WIDTH_RESET;
         poly_ff        <= POLY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FIELD_WIDTH:    field_width_ff <= csr_wdata[FIELD_W_W-1:0];
            CSR_REDUCTION_POLY: poly_ff        <= csr_wdata[ELEM_W-1:0];
         endcase
      end
   end

   // clamp to [2, MAX_FIELD_WIDTH]
   always_comb begin
      eff_width = field_width_ff;
      if (field_width_ff < MIN_FIELD_WIDTH) eff_width = MIN_FIELD_WIDTH;
      if (field_width_ff > MaxWidth)        eff_width = MaxWidth;
   end

   assign top_idx = eff_width - 7'd1;

   always_comb begin
      cfg.width = eff_width;
      for (int i = 0; i < ELEM_W; i++) begin
         cfg.mask[i] = (FIELD_W_W'(i) < eff_width);
         cfg.top[i]  = (FIELD_W_W'(i) == top_idx);
      end
      cfg.poly = poly_ff & cfg.mask;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/gf2m_cell.sv -----
// One cell of the multiplier chain: CELL_STEPS shift-and-add steps of the
// squaring and accumulator multipliers, registered. Depends on gf2m_pkg.
`default_nettype none

module gf2m_cell #(
   parameter int ROUND = 0,
   parameter bit FIRST = 1'b1,
   parameter bit LAST  = 1'b1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  gf2m_pkg::field_cfg_type     cfg,
   input  gf2m_pkg::stage_type         stage_i,
   output gf2m_pkg::stage_type         stage_o
);
   import gf2m_pkg::*;

   localparam logic [FIELD_W_W-1:0] RoundIdx = FIELD_W_W'(ROUND);

   stage_type stage_ff;
   stage_type stage_in;
   logic      acc_en;

   // multiply by x modulo the field polynomial
   function automatic logic [ELEM_W-1:0] xtime(input logic [ELEM_W-1:0] x,
                                                input field_cfg_type c);
      logic carry;
      carry = |(x & c.top);
      return ((x << 1) & c.mask) ^ ({ELEM_W{carry}} & c.poly);
   endfunction

   // whether this round multiplies the accumulator by the current power
   always_comb begin
      acc_en = 1'b0;
      case (stage_i.op) inside
         OP_MUL:         acc_en = (RoundIdx == 7'd0);
         OP_DIV, OP_INV: acc_en = (RoundIdx != 7'd0) && (RoundIdx < cfg.width);
         default:        acc_en = 1'b0;
      endcase
   end

   always_comb begin
      stage_in = stage_i;
      if (FIRST) begin
         // round start: s -> s*s, acc -> acc*s (or acc*1 when idle)
         stage_in.sy = stage_i.sx;
         stage_in.sp = '0;
         stage_in.ay = acc_en ? stage_i.sx : ELEM_ONE;
         stage_in.ap = '0;
      end
      for (int k = 0; k < CELL_STEPS; k++) begin
         stage_in.sp = stage_in.sp ^ ({ELEM_W{stage_in.sy[0]}} & stage_in.sx);
         stage_in.sy = stage_in.sy >> 1;
         stage_in.sx = xtime(stage_in.sx, cfg);
         stage_in.ap = stage_in.ap ^ ({ELEM_W{stage_in.ay[0]}} & stage_in.ax);
         stage_in.ay = stage_in.ay >> 1;
         stage_in.ax = xtime(stage_in.ax, cfg);
      end
      if (LAST) begin
         stage_in.sx = stage_in.sp;
         stage_in.ax = stage_in.ap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

`default_nettype wire
